// ===== sv/pwcr_pkg.sv =====
// ----------------------------------------------------------------------------
// pwcr_pkg
// Shared types, constants and arithmetic helpers for the tube wall capture
// and reflection pipeline.
// ----------------------------------------------------------------------------
package pwcr_pkg;

    localparam int DLT_W = 27;   // signed particle-to-centre offset once near
    localparam int MAG_W = 26;   // magnitude of that offset
    localparam int SQ_W  = 52;   // square of one offset component
    localparam int D2_W  = 53;   // squared distance
    localparam int DIV_W = 50;   // divisor width, squared distance on contact
    localparam int Q_W   = 34;   // quotient bits, one divider stage each
    localparam int TD_W  = 59;   // magnitude of twice the dot product
    localparam int LO_W  = 30;   // low slice of that magnitude per product
    localparam int NUM_W = 85;   // numerator of the reflection quotient
    localparam int ST_W  = DIV_W + Q_W;

    localparam logic signed [32:0] FAR_LIM = 33'sd67108864;

    localparam logic [1:0] REG_FREE = 2'd0;
    localparam logic [1:0] REG_ESC  = 2'd1;
    localparam logic [1:0] REG_T0   = 2'd2;
    localparam logic [1:0] REG_T1   = 2'd3;

    localparam logic [2:0] CFG_BOX_X_MIN = 3'd0;
    localparam logic [2:0] CFG_BOX_X_MAX = 3'd1;
    localparam logic [2:0] CFG_BOX_Y_MIN = 3'd2;
    localparam logic [2:0] CFG_BOX_Y_MAX = 3'd3;
    localparam logic [2:0] CFG_TUBE_RAD  = 3'd4;
    localparam logic [2:0] CFG_MARGIN    = 3'd5;
    localparam logic [2:0] CFG_TUBE0_CTR = 3'd6;
    localparam logic [2:0] CFG_TUBE1_CTR = 3'd7;

    typedef struct packed {
        logic              mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [23:0]        particle_radius;
        logic [1:0]         region_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic [1:0]         region_out;
        logic               reflected;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] box_x_min;
        logic signed [31:0] box_x_max;
        logic signed [31:0] box_y_min;
        logic signed [31:0] box_y_max;
        logic [23:0]        tube_rad;
        logic [23:0]        capture_margin;
        logic [63:0]        tube_zero_center;
        logic [63:0]        tube_one_center;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        box_x_min:        -32'sd3355443,
        box_x_max:        32'sd3355443,
        box_y_min:        -32'sd671089,
        box_y_max:        32'sd5033165,
        tube_rad:         24'd266757,
        capture_margin:   24'd234881,
        tube_zero_center: 64'd0,
        tube_one_center:  64'd989855
    };

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [1:0]         region;
        logic               refl;
    } t_side;

    typedef struct packed {
        t_side                   side;
        logic signed [DLT_W-1:0] dx;
        logic signed [DLT_W-1:0] dy;
        logic [DIV_W-1:0]        d2;
    } t_geo;

    typedef struct packed {
        t_side side;
        logic  neg_x;
        logic  neg_y;
    } t_div_side;

    function automatic logic signed [32:0] sub_ext(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        return 33'(a) - 33'(b);
    endfunction

    function automatic logic is_far(logic signed [32:0] d);
        return (d >= FAR_LIM) || (d <= -FAR_LIM);
    endfunction

    function automatic logic [SQ_W-1:0] sq(logic signed [DLT_W-1:0] a);
        logic signed [2*DLT_W-1:0] p;
        p = (2*DLT_W)'(a) * (2*DLT_W)'(a);
        return p[SQ_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] mag(logic signed [DLT_W-1:0] a);
        logic signed [DLT_W-1:0] m;
        m = (a < 0) ? -a : a;
        return m[MAG_W-1:0];
    endfunction

    // One restoring step: state is {remainder, low numerator / quotient bits}.
    function automatic logic [ST_W-1:0] div_step(logic [ST_W-1:0] st,
                                                 logic [DIV_W-1:0] d);
        logic [DIV_W:0] t;
        logic [DIV_W:0] diff;
        logic           ge;
        t    = {st[ST_W-1:Q_W], st[Q_W-1]};
        diff = t - {1'b0, d};
        ge   = (t >= {1'b0, d});
        return {(ge ? diff[DIV_W-1:0] : t[DIV_W-1:0]), st[Q_W-2:0], ge};
    endfunction

    function automatic logic signed [31:0] finish(logic [Q_W-1:0] q, logic neg,
                                                  logic signed [31:0] v);
        logic signed [35:0] sq_q;
        logic signed [35:0] r;
        sq_q = neg ? -$signed(36'(q)) : $signed(36'(q));
        r    = sq_q - 36'(v);
        if (r > 36'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (r < -36'sd2147483648) begin
            return 32'sh80000000;
        end
        return r[31:0];
    endfunction

endpackage

// ===== sv/pwcr_front.sv =====
// ----------------------------------------------------------------------------
// pwcr_front
// Geometry stages: offsets to both tubes, squared distances, classification
// and tube selection.
// ----------------------------------------------------------------------------
module pwcr_front import pwcr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_vld,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output logic     o_vld,
    output t_geo     o_geo
);

    logic signed [32:0] n_dx0, n_dy0, n_dx1, n_dy1;

    logic                    r1_vld, r1_mode, r1_out, r1_far0, r1_far1;
    t_side                   r1_side;
    logic signed [DLT_W-1:0] r1_dx0, r1_dy0, r1_dx1, r1_dy1;
    logic [24:0]             r1_s, r1_cr;

    logic                    r2_vld, r2_mode, r2_out, r2_far0, r2_far1;
    t_side                   r2_side;
    logic signed [DLT_W-1:0] r2_dx0, r2_dy0, r2_dx1, r2_dy1;
    logic [SQ_W-1:0]         r2_sqx0, r2_sqy0, r2_sqx1, r2_sqy1;
    logic [49:0]             r2_s2, r2_cr2;

    logic [D2_W-1:0] w_d20, w_d21;
    logic            w_cap0, w_cap1, w_con0, w_con1, w_sel;
    t_geo            n_geo;
    logic            r3_vld;
    t_geo            r3_geo;

    assign n_dx0 = sub_ext(i_item.pos_x, signed'(i_cfg.tube_zero_center[63:32]));
    assign n_dy0 = sub_ext(i_item.pos_y, signed'(i_cfg.tube_zero_center[31:0]));
    assign n_dx1 = sub_ext(i_item.pos_x, signed'(i_cfg.tube_one_center[63:32]));
    assign n_dy1 = sub_ext(i_item.pos_y, signed'(i_cfg.tube_one_center[31:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    // Stage 1: offsets, far flags, box test, radius sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mode        <= i_item.mode;
            r1_side.vel_x  <= i_item.vel_x;
            r1_side.vel_y  <= i_item.vel_y;
            r1_side.region <= i_item.region_in;
            r1_side.refl   <= 1'b0;
            r1_out  <= (i_item.pos_x < i_cfg.box_x_min) || (i_item.pos_x > i_cfg.box_x_max)
                    || (i_item.pos_y < i_cfg.box_y_min) || (i_item.pos_y > i_cfg.box_y_max);
            r1_far0 <= is_far(n_dx0) || is_far(n_dy0);
            r1_far1 <= is_far(n_dx1) || is_far(n_dy1);
            r1_dx0  <= n_dx0[DLT_W-1:0];
            r1_dy0  <= n_dy0[DLT_W-1:0];
            r1_dx1  <= n_dx1[DLT_W-1:0];
            r1_dy1  <= n_dy1[DLT_W-1:0];
            r1_s    <= 25'(i_item.particle_radius) + 25'(i_cfg.tube_rad);
            r1_cr   <= 25'(i_cfg.tube_rad) + 25'(i_cfg.capture_margin);
        end
    end

    // Stage 2: squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_mode <= r1_mode;
            r2_side <= r1_side;
            r2_out  <= r1_out;
            r2_far0 <= r1_far0;
            r2_far1 <= r1_far1;
            r2_dx0  <= r1_dx0;
            r2_dy0  <= r1_dy0;
            r2_dx1  <= r1_dx1;
            r2_dy1  <= r1_dy1;
            r2_sqx0 <= sq(r1_dx0);
            r2_sqy0 <= sq(r1_dy0);
            r2_sqx1 <= sq(r1_dx1);
            r2_sqy1 <= sq(r1_dy1);
            r2_s2   <= 50'(r1_s) * 50'(r1_s);
            r2_cr2  <= 50'(r1_cr) * 50'(r1_cr);
        end
    end

    // Stage 3: distances, capture and contact decision
    assign w_d20  = D2_W'(r2_sqx0) + D2_W'(r2_sqy0);
    assign w_d21  = D2_W'(r2_sqx1) + D2_W'(r2_sqy1);
    assign w_cap0 = !r2_far0 && (w_d20 < D2_W'(r2_cr2));
    assign w_cap1 = !r2_far1 && (w_d21 < D2_W'(r2_cr2));
    assign w_con0 = !r2_far0 && (w_d20 != '0) && (w_d20 < D2_W'(r2_s2));
    assign w_con1 = !r2_far1 && (w_d21 != '0) && (w_d21 < D2_W'(r2_s2));

    always_comb begin
        n_geo.side = r2_side;
        w_sel      = 1'b0;
        if (!r2_mode) begin
            if (r2_side.region == REG_T0) begin
                n_geo.side.refl = w_con0;
            end else if (r2_side.region == REG_T1) begin
                n_geo.side.refl = w_con1;
                w_sel           = 1'b1;
            end
        end else if (r2_side.region != REG_ESC) begin
            if (r2_out) begin
                n_geo.side.region = REG_ESC;
            end else if (w_cap0) begin
                n_geo.side.region = REG_T0;
                n_geo.side.refl   = w_con0;
            end else if (w_cap1) begin
                n_geo.side.region = REG_T1;
                n_geo.side.refl   = w_con1;
                w_sel             = 1'b1;
            end else begin
                n_geo.side.region = REG_FREE;
            end
        end
        n_geo.dx = w_sel ? r2_dx1 : r2_dx0;
        n_geo.dy = w_sel ? r2_dy1 : r2_dy0;
        n_geo.d2 = w_sel ? w_d21[DIV_W-1:0] : w_d20[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_geo <= n_geo;
        end
    end

    assign o_vld = r3_vld;
    assign o_geo = r3_geo;

endmodule

// ===== sv/pwcr_mul.sv =====
// ----------------------------------------------------------------------------
// pwcr_mul
// Product stages: dot product with the wall tangent and the two
// reflection numerators, built from partial products.
// ----------------------------------------------------------------------------
module pwcr_mul import pwcr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_geo             i_geo,
    output logic             o_vld,
    output logic [NUM_W-1:0] o_num_x,
    output logic [NUM_W-1:0] o_num_y,
    output logic [DIV_W-1:0] o_d2,
    output t_div_side        o_side
);

    logic signed [DLT_W-1:0] w_ny;
    logic                    r4_vld, r5_vld, r6_vld, r7_vld;
    t_geo                    r4_geo;
    logic signed [58:0]      r4_px, r4_py;

    logic signed [59:0]      w_dot;
    logic signed [60:0]      w_td;
    logic signed [60:0]      w_tdm;
    t_div_side               r5_side, r6_side, r7_side;
    logic [DIV_W-1:0]        r5_d2, r6_d2, r7_d2;
    logic [TD_W-1:0]         r5_td;
    logic [MAG_W-1:0]        r5_tx, r5_ty;

    logic [LO_W+MAG_W-1:0]        r6_lox, r6_loy;
    logic [TD_W-LO_W+MAG_W-1:0]   r6_hix, r6_hiy;
    logic [NUM_W-1:0]             r7_nx, r7_ny;

    assign w_ny  = -i_geo.dy;
    assign w_dot = 60'(r4_px) + 60'(r4_py);
    assign w_td  = 61'(w_dot) <<< 1;
    assign w_tdm = (w_td < 0) ? -w_td : w_td;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= i_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 4: v_x * (-dy) and v_y * dx
            r4_geo <= i_geo;
            r4_px  <= 59'(i_geo.side.vel_x) * 59'(w_ny);
            r4_py  <= 59'(i_geo.side.vel_y) * 59'(i_geo.dx);
            // stage 5: magnitudes and result signs
            r5_side.side  <= r4_geo.side;
            r5_side.neg_x <= (w_td < 0) ^ (r4_geo.dy > 0);
            r5_side.neg_y <= (w_td < 0) ^ (r4_geo.dx < 0);
            r5_d2 <= r4_geo.d2;
            r5_td <= w_tdm[TD_W-1:0];
            r5_tx <= mag(r4_geo.dy);
            r5_ty <= mag(r4_geo.dx);
            // stage 6: partial products
            r6_side <= r5_side;
            r6_d2   <= r5_d2;
            r6_lox  <= (LO_W+MAG_W)'(r5_td[LO_W-1:0]) * (LO_W+MAG_W)'(r5_tx);
            r6_loy  <= (LO_W+MAG_W)'(r5_td[LO_W-1:0]) * (LO_W+MAG_W)'(r5_ty);
            r6_hix  <= (TD_W-LO_W+MAG_W)'(r5_td[TD_W-1:LO_W]) * (TD_W-LO_W+MAG_W)'(r5_tx);
            r6_hiy  <= (TD_W-LO_W+MAG_W)'(r5_td[TD_W-1:LO_W]) * (TD_W-LO_W+MAG_W)'(r5_ty);
            // stage 7: combine
            r7_side <= r6_side;
            r7_d2   <= r6_d2;
            r7_nx   <= (NUM_W'(r6_hix) << LO_W) + NUM_W'(r6_lox);
            r7_ny   <= (NUM_W'(r6_hiy) << LO_W) + NUM_W'(r6_loy);
        end
    end

    assign o_vld   = r7_vld;
    assign o_num_x = r7_nx;
    assign o_num_y = r7_ny;
    assign o_d2    = r7_d2;
    assign o_side  = r7_side;

endmodule

// ===== sv/pwcr_div.sv =====
// ----------------------------------------------------------------------------
// pwcr_div
// Pipelined restoring divider, one quotient bit per stage, for both
// velocity components sharing one divisor.
// ----------------------------------------------------------------------------
module pwcr_div import pwcr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [NUM_W-1:0] i_num_x,
    input  logic [NUM_W-1:0] i_num_y,
    input  logic [DIV_W-1:0] i_d2,
    input  t_div_side        i_side,
    output logic             o_vld,
    output logic [Q_W-1:0]   o_q_x,
    output logic [Q_W-1:0]   o_q_y,
    output t_div_side        o_side
);

    logic             w_vld  [Q_W+1];
    logic [ST_W-1:0]  w_x    [Q_W+1];
    logic [ST_W-1:0]  w_y    [Q_W+1];
    logic [DIV_W-1:0] w_d2   [Q_W+1];
    t_div_side        w_side [Q_W+1];

    // Top numerator bit is zero whenever the quotient is used
    assign w_vld[0]  = i_vld;
    assign w_x[0]    = i_num_x[ST_W-1:0];
    assign w_y[0]    = i_num_y[ST_W-1:0];
    assign w_d2[0]   = i_d2;
    assign w_side[0] = i_side;

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic             r_vld;
        logic [ST_W-1:0]  r_x, r_y;
        logic [DIV_W-1:0] r_d2;
        t_div_side        r_side;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x    <= div_step(w_x[s], w_d2[s]);
                r_y    <= div_step(w_y[s], w_d2[s]);
                r_d2   <= w_d2[s];
                r_side <= w_side[s];
            end
        end

        assign w_vld[s+1]  = r_vld;
        assign w_x[s+1]    = r_x;
        assign w_y[s+1]    = r_y;
        assign w_d2[s+1]   = r_d2;
        assign w_side[s+1] = r_side;
    end

    assign o_vld  = w_vld[Q_W];
    assign o_q_x  = w_x[Q_W][Q_W-1:0];
    assign o_q_y  = w_y[Q_W][Q_W-1:0];
    assign o_side = w_side[Q_W];

endmodule

// ===== sv/particle_wall_capture_reflect.sv =====
// ----------------------------------------------------------------------------
// particle_wall_capture_reflect
// Tube capture classification and specular wall reflection of particles.
// ----------------------------------------------------------------------------
// One particle transaction enters per clock and one result leaves per clock
// while results are taken; the pipeline is 42 registers deep (3 geometry
// stages, 4 product stages, 34 divider stages of one quotient bit each, 1
// output register). The whole pipeline advances together: it holds while a
// result waits at the output and is not taken, and o_in_ready drops only
// then.
// In recapture mode a particle outside the box turns escaped, otherwise it is
// captured by the first tube within the tube radius plus capture margin; in
// plain mode only a particle already in a tube is tested against that tube.
// On wall contact the velocity is mirrored about the wall tangent and
// saturated to Q16.16. Registers sit at byte addresses 8*i on the APB port
// and must be written only while the pipeline is empty.
// ----------------------------------------------------------------------------
module particle_wall_capture_reflect import pwcr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    t_cfg             r_cfg;
    logic [2:0]       w_idx;
    logic             w_en;

    logic             w_geo_vld, w_mul_vld, w_div_vld;
    t_geo             w_geo;
    logic [NUM_W-1:0] w_num_x, w_num_y;
    logic [DIV_W-1:0] w_d2;
    t_div_side        w_mul_side, w_div_side;
    logic [Q_W-1:0]   w_q_x, w_q_y;

    logic             r_out_vld;
    t_out_item        r_out;
    t_out_item        n_out;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                CFG_BOX_X_MIN: r_cfg.box_x_min        <= pwdata[31:0];
                CFG_BOX_X_MAX: r_cfg.box_x_max        <= pwdata[31:0];
                CFG_BOX_Y_MIN: r_cfg.box_y_min        <= pwdata[31:0];
                CFG_BOX_Y_MAX: r_cfg.box_y_max        <= pwdata[31:0];
                CFG_TUBE_RAD:  r_cfg.tube_rad         <= pwdata[23:0];
                CFG_MARGIN:    r_cfg.capture_margin   <= pwdata[23:0];
                CFG_TUBE0_CTR: r_cfg.tube_zero_center <= pwdata;
                CFG_TUBE1_CTR: r_cfg.tube_one_center  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            CFG_BOX_X_MIN: prdata = {32'd0, r_cfg.box_x_min};
            CFG_BOX_X_MAX: prdata = {32'd0, r_cfg.box_x_max};
            CFG_BOX_Y_MIN: prdata = {32'd0, r_cfg.box_y_min};
            CFG_BOX_Y_MAX: prdata = {32'd0, r_cfg.box_y_max};
            CFG_TUBE_RAD:  prdata = {40'd0, r_cfg.tube_rad};
            CFG_MARGIN:    prdata = {40'd0, r_cfg.capture_margin};
            CFG_TUBE0_CTR: prdata = r_cfg.tube_zero_center;
            CFG_TUBE1_CTR: prdata = r_cfg.tube_one_center;
            default:       prdata = '0;
        endcase
    end

    // ---------------- pipeline ----------------
    // Advance every stage whenever the output register is free or being read.
    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en;

    pwcr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid),
        .i_item  (i_in_item),
        .i_cfg   (r_cfg),
        .o_vld   (w_geo_vld),
        .o_geo   (w_geo)
    );

    pwcr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_geo_vld),
        .i_geo   (w_geo),
        .o_vld   (w_mul_vld),
        .o_num_x (w_num_x),
        .o_num_y (w_num_y),
        .o_d2    (w_d2),
        .o_side  (w_mul_side)
    );

    pwcr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_mul_vld),
        .i_num_x (w_num_x),
        .i_num_y (w_num_y),
        .i_d2    (w_d2),
        .i_side  (w_mul_side),
        .o_vld   (w_div_vld),
        .o_q_x   (w_q_x),
        .o_q_y   (w_q_y),
        .o_side  (w_div_side)
    );

    // Apply the sign, subtract the old velocity and saturate; without contact
    // pass the velocity through untouched.
    always_comb begin
        n_out.region_out = w_div_side.side.region;
        n_out.reflected  = w_div_side.side.refl;
        if (w_div_side.side.refl) begin
            n_out.new_vel_x = finish(w_q_x, w_div_side.neg_x, w_div_side.side.vel_x);
            n_out.new_vel_y = finish(w_q_y, w_div_side.neg_y, w_div_side.side.vel_y);
        end else begin
            n_out.new_vel_x = w_div_side.side.vel_x;
            n_out.new_vel_y = w_div_side.side.vel_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // ---------------- assertions ----------------
    a_refl_in_tube: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.reflected |->
            (o_out_item.region_out == REG_T0) || (o_out_item.region_out == REG_T1))
        else $error("reflection reported outside a tube");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_div_vld) && $stable(w_div_side))
        else $error("divider stage moved during a stall");

endmodule
